// File: rtl/amrsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrsh_pkg
// Shared types and constants for the AM retransmission segment header builder.
// ----------------------------------------------------------------------------
package amrsh_pkg;

    localparam int IN_TDATA_W      = 88;
    localparam int OUT_TDATA_W     = 80;
    localparam int OUT_TUSER_W     = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ZERO_LEN    = 2'd1,
        ST_BEYOND_SDU  = 2'd2,
        ST_GRANT_SMALL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SI_FULL   = 2'd0,
        SI_FIRST  = 2'd1,
        SI_LAST   = 2'd2,
        SI_MIDDLE = 2'd3
    } seg_info_t;

    typedef struct packed {
        logic [15:0] grant_length;
        logic [15:0] sdu_length;
        logic [15:0] seg_length;
        logic [15:0] seg_offset;
        logic [17:0] seq_number;
    } req_t;

    typedef struct packed {
        status_t     status;
        seg_info_t   seg_info;
        logic [7:0]  byte0;
        logic [15:0] sn_low;
        logic [15:0] seg_offset;
        logic        sn_18;
        logic [2:0]  last_idx;
        logic [15:0] payload_length;
        logic [16:0] pdu_length;
        logic [15:0] next_offset;
        logic [15:0] remaining_length;
    } desc_t;

endpackage

// File: rtl/amrsh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrsh_front
// Two-stage request classifier: checks the request, fits the payload to the
// grant and builds one header descriptor per request.
// ----------------------------------------------------------------------------
module amrsh_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sn_18,
    input  logic              in_valid,
    output logic              in_ready,
    input  amrsh_pkg::req_t   in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output amrsh_pkg::desc_t  out_desc
);
    import amrsh_pkg::*;

    logic        a_valid_reg;
    logic        a_valid_next;
    req_t        a_req_reg;
    logic        a_ready;

    logic        b_valid_reg;
    logic        b_valid_next;
    req_t        b_req_reg;
    logic        b_zero_reg;
    logic        b_beyond_reg;
    logic        b_small_reg;
    logic        b_so_nz_reg;
    logic [2:0]  b_hdr_reg;
    logic [15:0] b_avail_reg;
    logic        b_ready;

    logic        a_so_nz;
    logic [2:0]  a_hdr;
    logic [16:0] a_end;
    logic        a_beyond;
    logic        a_small;
    logic [15:0] a_avail;

    logic [15:0] pay;
    logic [16:0] sum_next;
    logic        sdu_done;
    seg_info_t   si;
    status_t     st;
    logic [3:0]  nib;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        a_so_nz  = |a_req_reg.seg_offset;
        a_hdr    = (sn_18 ? 3'd3 : 3'd2) + (a_so_nz ? 3'd2 : 3'd0);
        a_end    = {1'b0, a_req_reg.seg_offset} + {1'b0, a_req_reg.seg_length};
        a_beyond = a_end > {1'b0, a_req_reg.sdu_length};
        a_small  = a_req_reg.grant_length <= {13'd0, a_hdr};
        a_avail  = a_req_reg.grant_length - {13'd0, a_hdr};
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_ready)
        begin
            a_valid_next = in_valid;
        end
        b_valid_next = b_valid_reg;
        if (b_ready)
        begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_req_reg <= in_req;
        end
        if (b_ready && a_valid_reg)
        begin
            b_req_reg    <= a_req_reg;
            b_zero_reg   <= a_req_reg.seg_length == 16'd0;
            b_beyond_reg <= a_beyond;
            b_small_reg  <= a_small;
            b_so_nz_reg  <= a_so_nz;
            b_hdr_reg    <= a_hdr;
            b_avail_reg  <= a_avail;
        end
    end

    always_comb
    begin
        pay      = (b_req_reg.seg_length < b_avail_reg) ? b_req_reg.seg_length : b_avail_reg;
        sum_next = {1'b0, b_req_reg.seg_offset} + {1'b0, pay};
        sdu_done = sum_next >= {1'b0, b_req_reg.sdu_length};
        if (b_so_nz_reg)
        begin
            si = sdu_done ? SI_LAST : SI_MIDDLE;
        end
        else
        begin
            si = sdu_done ? SI_FULL : SI_FIRST;
        end
        if (b_zero_reg)
        begin
            st = ST_ZERO_LEN;
        end
        else if (b_beyond_reg)
        begin
            st = ST_BEYOND_SDU;
        end
        else if (b_small_reg)
        begin
            st = ST_GRANT_SMALL;
        end
        else
        begin
            st = ST_OK;
        end
        nib = sn_18 ? {2'b00, b_req_reg.seq_number[17:16]} : b_req_reg.seq_number[11:8];

        out_desc.status     = st;
        out_desc.sn_low     = b_req_reg.seq_number[15:0];
        out_desc.seg_offset = b_req_reg.seg_offset;
        out_desc.sn_18      = sn_18;
        if (st == ST_OK)
        begin
            out_desc.seg_info         = si;
            out_desc.byte0            = {2'b10, si, nib};
            out_desc.last_idx         = b_hdr_reg - 3'd1;
            out_desc.payload_length   = pay;
            out_desc.pdu_length       = {1'b0, pay} + {14'd0, b_hdr_reg};
            out_desc.next_offset      = sum_next[16] ? 16'hffff : sum_next[15:0];
            out_desc.remaining_length = b_req_reg.seg_length - pay;
        end
        else
        begin
            out_desc.seg_info         = SI_FULL;
            out_desc.byte0            = 8'd0;
            out_desc.last_idx         = 3'd0;
            out_desc.payload_length   = 16'd0;
            out_desc.pdu_length       = 17'd0;
            out_desc.next_offset      = b_req_reg.seg_offset;
            out_desc.remaining_length = b_req_reg.seg_length;
        end
    end

    assign out_valid = b_valid_reg;

endmodule

// File: rtl/amrsh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrsh_queue
// Short descriptor queue between the classifier and the header emitter.
// ----------------------------------------------------------------------------
module amrsh_queue
#(
    parameter int DEPTH = amrsh_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  amrsh_pkg::desc_t  wr_desc,
    output logic              rd_valid,
    input  logic              rd_ready,
    output amrsh_pkg::desc_t  rd_desc
);
    import amrsh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    desc_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_desc  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

// File: rtl/amrsh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrsh_back
// Header emitter: walks one descriptor byte by byte into the output register.
// ----------------------------------------------------------------------------
module amrsh_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    output logic                                  q_ready,
    input  amrsh_pkg::desc_t                      q_desc,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [amrsh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [amrsh_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import amrsh_pkg::*;

    logic                   cur_valid_reg;
    logic                   cur_valid_next;
    desc_t                  cur_desc_reg;
    logic [2:0]             idx_reg;
    logic [2:0]             idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                   out_last_reg;

    logic                   load_out;
    logic                   is_last;
    logic                   pop;
    logic [2:0]             pos;
    logic [7:0]             hdr_byte;

    assign load_out = cur_valid_reg && (!out_valid_reg || m_axis_tready);
    assign is_last  = idx_reg == cur_desc_reg.last_idx;
    assign pop      = q_valid && (!cur_valid_reg || (load_out && is_last));
    assign q_ready  = !cur_valid_reg || (load_out && is_last);

    always_comb
    begin
        pos = cur_desc_reg.sn_18 ? idx_reg : idx_reg + 3'd1;
        if (idx_reg == 3'd0)
        begin
            hdr_byte = cur_desc_reg.byte0;
        end
        else
        begin
            case (pos)
                3'd1:    hdr_byte = cur_desc_reg.sn_low[15:8];
                3'd2:    hdr_byte = cur_desc_reg.sn_low[7:0];
                3'd3:    hdr_byte = cur_desc_reg.seg_offset[15:8];
                3'd4:    hdr_byte = cur_desc_reg.seg_offset[7:0];
                default: hdr_byte = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 3'd1;
            if (is_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_desc_reg <= q_desc;
        end
        if (load_out)
        begin
            out_data_reg <= {7'd0,
                             cur_desc_reg.remaining_length,
                             cur_desc_reg.next_offset,
                             cur_desc_reg.pdu_length,
                             cur_desc_reg.payload_length,
                             hdr_byte};
            out_user_reg <= {cur_desc_reg.seg_info, cur_desc_reg.status};
            out_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/am_retx_segment_header_builder_core.sv
`timescale 1ns / 1ps
// Throughput: one byte per cycle unless the output stalls, so an accepted request
// holds the output for two to five bytes, one byte for a rejected request.
// The front accepts a new request every cycle while the descriptor queue has room.
// Reset (rst_n low, asynchronous) empties all stages and selects the 12-bit SN header.
// ----------------------------------------------------------------------------
// am_retx_segment_header_builder_core
// AM data PDU header builder for retransmission requests: classifier, queue
// and byte emitter.
// ----------------------------------------------------------------------------
module am_retx_segment_header_builder_core
#(
    parameter int QUEUE_DEPTH = amrsh_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // seq_number[17:0], seg_offset[33:18], seg_length[49:34],
    // sdu_length[65:50], grant_length[81:66], zero fill above.
    input  logic [amrsh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // header_byte[7:0], payload_length[23:8], pdu_length[40:24],
    // next_offset[56:41], remaining_length[72:57], zero fill above.
    output logic [amrsh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0], segment_info[3:2].
    output logic [amrsh_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                               m_axis_tlast
);
    import amrsh_pkg::*;

    logic  sn_18_reg;
    req_t  in_req;
    logic  f_valid;
    logic  f_ready;
    desc_t f_desc;
    logic  q_valid;
    logic  q_ready;
    desc_t q_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sn_18_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            sn_18_reg <= cfg_data;
        end
    end

    assign in_req = s_axis_tdata[$bits(req_t)-1:0];

    amrsh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sn_18     (sn_18_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_desc  (f_desc)
    );

    amrsh_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_desc  (f_desc),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_desc  (q_desc)
    );

    amrsh_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_desc        (q_desc),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
